// File: rtl/core/shp_pkg.sv
// shared types, command and motion codes, and the half-step coil table
package shp_pkg;

    localparam int PosW = 16;

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_SET  = 2'd1;
    localparam logic [1:0] CMD_INIT = 2'd2;

    localparam logic [1:0] MOT_STOP  = 2'd0;
    localparam logic [1:0] MOT_OPEN  = 2'd1;
    localparam logic [1:0] MOT_CLOSE = 2'd2;

    localparam logic [PosW-1:0] INVALID_STORED = 16'hFFFF;
    localparam logic [PosW-1:0] INIT_OFFSET    = 16'd10;

    localparam logic [3:0] PHASE_FIRST = 4'd1;
    localparam logic [3:0] PHASE_LAST  = 4'd8;
    localparam logic [3:0] COILS_OFF   = 4'h0;

    // packed so the first field sits in the highest bits
    typedef struct packed {
        logic            power_fail;
        logic [PosW-1:0] stored_position;
        logic            extra_step;
        logic [PosW-1:0] target_position;
        logic [1:0]      command;
    } in_item_t;

    typedef struct packed {
        logic [PosW-1:0] position;
        logic [1:0]      motion;
        logic [3:0]      coil_pattern;
    } out_item_t;

    // coil bits: bit3 A, bit2 B, bit1 C, bit0 D
    function automatic logic [3:0] pattern_of_phase(input logic [3:0] phase);
        logic [3:0] pat;
        begin
            case (phase)
                4'd1:    pat = 4'h9;
                4'd2:    pat = 4'h8;
                4'd3:    pat = 4'hA;
                4'd4:    pat = 4'h2;
                4'd5:    pat = 4'h6;
                4'd6:    pat = 4'h4;
                4'd7:    pat = 4'h5;
                4'd8:    pat = 4'h1;
                default: pat = COILS_OFF;
            endcase
            return pat;
        end
    endfunction

endpackage

// File: rtl/core/shp_in_stage.sv
// input register stage holding one accepted command
module shp_in_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  shp_pkg::in_item_t in_item,
    output logic             held_valid,
    output shp_pkg::in_item_t held_item,
    input  logic             take
);
    import shp_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

// File: rtl/core/shp_step.sv
// controller state and the single-pass command logic
module shp_step (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_value,
    input  logic              fire,
    input  shp_pkg::in_item_t item,
    output shp_pkg::out_item_t result
);
    import shp_pkg::*;

    logic [PosW-1:0] max_position_reg;
    logic [3:0]      phase_reg;
    logic [3:0]      phase_next;
    logic [PosW-1:0] current_position_reg;
    logic [PosW-1:0] current_position_next;
    logic [PosW-1:0] commanded_position_reg;
    logic [PosW-1:0] commanded_position_next;
    logic [1:0]      motion_reg;
    logic [1:0]      motion_next;
    logic [3:0]      coils_reg;
    logic [3:0]      coils_next;
    logic            phase_ok;
    logic [3:0]      phase_back;

    assign phase_ok   = (phase_reg >= PHASE_FIRST) && (phase_reg <= PHASE_LAST);
    assign phase_back = (phase_reg == PHASE_FIRST) ? PHASE_LAST : phase_reg - 4'd1;

    always_comb
    begin
        phase_next              = phase_reg;
        current_position_next   = current_position_reg;
        commanded_position_next = commanded_position_reg;
        motion_next             = motion_reg;
        coils_next              = coils_reg;
        case (item.command)
            CMD_TICK:
            begin
                if (commanded_position_reg < current_position_reg)
                begin
                    motion_next           = MOT_OPEN;
                    current_position_next = current_position_reg - 16'd1;
                    if (phase_ok)
                    begin
                        phase_next = phase_back;
                        coils_next = pattern_of_phase(phase_back);
                    end
                end
                else if (commanded_position_reg > current_position_reg)
                begin
                    motion_next           = MOT_CLOSE;
                    current_position_next = current_position_reg + 16'd1;
                    if (phase_ok)
                    begin
                        coils_next = pattern_of_phase(phase_reg);
                        phase_next = (phase_reg == PHASE_LAST) ? PHASE_FIRST
                                                               : phase_reg + 4'd1;
                    end
                end
                else
                begin
                    motion_next = MOT_STOP;
                    coils_next  = COILS_OFF;
                end
            end
            CMD_SET:
            begin
                // clamp above max to max plus the extra step, wrapping at 16 bits
                if (item.target_position > max_position_reg)
                begin
                    commanded_position_next = max_position_reg
                                              + {{(PosW-1){1'b0}}, item.extra_step};
                end
                else
                begin
                    commanded_position_next = item.target_position;
                end
            end
            CMD_INIT:
            begin
                coils_next              = COILS_OFF;
                phase_next              = PHASE_FIRST;
                motion_next             = MOT_STOP;
                commanded_position_next = '0;
                if (item.power_fail || (item.stored_position == INVALID_STORED))
                begin
                    current_position_next = max_position_reg + INIT_OFFSET;
                end
                else
                begin
                    current_position_next = item.stored_position;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_position_reg       <= '0;
            phase_reg              <= PHASE_FIRST;
            current_position_reg   <= '0;
            commanded_position_reg <= '0;
            motion_reg             <= MOT_STOP;
            coils_reg              <= COILS_OFF;
        end
        else
        begin
            if (cfg_we)
            begin
                max_position_reg <= cfg_value;
            end
            if (fire)
            begin
                phase_reg              <= phase_next;
                current_position_reg   <= current_position_next;
                commanded_position_reg <= commanded_position_next;
                motion_reg             <= motion_next;
                coils_reg              <= coils_next;
            end
        end
    end

    assign result.coil_pattern = coils_next;
    assign result.motion       = motion_next;
    assign result.position     = current_position_next;

endmodule

// File: rtl/core/shp_out_stage.sv
// result register on the master side
module shp_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  shp_pkg::out_item_t load_item,
    output logic               can_load,
    output logic               out_valid,
    input  logic               out_ready,
    output shp_pkg::out_item_t out_item
);
    import shp_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : ((valid_reg && out_ready) ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= load_item;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// File: rtl/core/stepper_half_step_position_control.sv
// half-step stepper position controller, top level
// an accepted transaction goes through the input register, then the result register, to the master side
// throughput: one transaction per cycle while m_tready does not hold a waiting result
// the input register and result register let a new transaction in while a result waits
// reset: async active low; phase 1, positions 0, motion stopped, coils off, max 0
module stepper_half_step_position_control (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,      // max_position
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,       // target_position, extra_step, stored_position, power_fail
    input  logic [1:0]  s_tuser,       // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata        // coil_pattern, motion, position
);
    import shp_pkg::*;

    in_item_t  in_item;
    in_item_t  held_item;
    out_item_t step_result;
    out_item_t out_item;
    logic      held_valid;
    logic      can_load;
    logic      fire;

    assign in_item.command         = s_tuser;
    assign in_item.target_position = s_tdata[15:0];
    assign in_item.extra_step      = s_tdata[16];
    assign in_item.stored_position = s_tdata[32:17];
    assign in_item.power_fail      = s_tdata[33];

    assign cfg_ready = 1'b1;
    assign fire      = held_valid && can_load;

    shp_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .held_valid (held_valid),
        .held_item  (held_item),
        .take       (fire)
    );

    shp_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid),
        .cfg_value (cfg_data),
        .fire      (fire),
        .item      (held_item),
        .result    (step_result)
    );

    shp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .load_item (step_result),
        .can_load  (can_load),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    assign m_tdata = {2'b00, out_item};

endmodule
